@@ hdl/pls_pkg.sv @@
// pls_pkg: shared constants, codes and types of the positional list store
// depends on nothing; imported by pls_cell and positional_list_store_core
package pls_pkg;

    localparam int PLS_DEPTH  = 16;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 7;   // magnitude bits of the signed position
    localparam int CNT_W      = 5;   // fill count, bounded by the 5-bit capacity
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 3;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISSING  = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_POS  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_ENTRY = 3'd4;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic             shift_up;  // accepted insert
        logic             shift_dn;  // accepted delete
        logic [POS_W-1:0] pos;       // clamped for insert, raw for get and delete
        logic [CNT_W-1:0] count;     // fill count before this request
    } pls_cmd_t;

endpackage

@@ hdl/positional_list_store_core.sv @@
// positional_list_store_core: packed ordered word list built from a row of cells
// depends on pls_pkg and pls_cell
// latency: a request accepted at one edge has its result on m_tdata after that edge
// throughput: one request per cycle if s_tready is high; all entries shift in one step
// s_tready drops only while a finished result waits on a stalled master side
// reset clears the fill count, the output valid and sets the capacity to 16
// entry words are not reset; a cleared list never reads them
module positional_list_store_core
    import pls_pkg::*;
#(
    parameter int DEPTH = PLS_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: active capacity
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] position (signed), [39:8] item_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] status, [34:3] read_value, [39:35] list_length
);

    localparam logic [7:0] DEPTH_W8 = 8'(DEPTH);

    // configuration and fill state
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [WORD_W-1:0] out_read_reg;
    logic [CNT_W-1:0]  out_len_reg;

    // request fields
    logic              req_acc;
    logic [ACT_W-1:0]  req_action;
    logic              req_neg;
    logic [POS_W-1:0]  req_pos;
    logic [WORD_W-1:0] req_word;

    logic [CNT_W-1:0]  eff_cap;
    logic [POS_W-1:0]  cap_ext;
    logic [POS_W-1:0]  count_ext;
    logic [POS_W-1:0]  ins_pos;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] read_word;
    logic [WORD_W-1:0] read_bus;
    pls_cmd_t          cmd;

    logic [WORD_W-1:0] cell_value [DEPTH];
    logic [WORD_W-1:0] cell_tap   [DEPTH];

    assign req_acc    = s_tvalid && s_tready;
    assign req_action = s_tuser;
    assign req_neg    = s_tdata[7];
    assign req_pos    = s_tdata[6:0];
    assign req_word   = s_tdata[39:8];

    // effective capacity: the smaller of the register and the cell count
    assign eff_cap   = ({3'b000, cap_reg} < DEPTH_W8) ? cap_reg : CNT_W'(DEPTH_W8);
    assign cap_ext   = POS_W'(eff_cap);
    assign count_ext = POS_W'(count_reg);
    // a position past the end is clamped to the current length
    assign ins_pos   = (req_pos > count_ext) ? count_ext : req_pos;

    always_comb
    begin
        status     = ST_OK;
        read_word  = '0;
        count_next = count_reg;
        cmd        = '0;
        cmd.count  = count_reg;
        cmd.pos    = req_pos;
        unique case (req_action) inside
            ACT_INSERT:
            begin
                cmd.pos = ins_pos;
                if (req_word == '0)
                    status = ST_MISSING;
                else if (req_neg || req_pos >= cap_ext)
                    status = ST_BAD_POS;
                else if (count_reg >= eff_cap)
                    status = ST_FULL;
                else
                begin
                    cmd.shift_up = req_acc;
                    count_next   = count_reg + 1'b1;
                end
            end
            ACT_GET, ACT_DELETE:
            begin
                if (req_neg || req_pos >= count_ext)
                    status = ST_NO_ENTRY;
                else
                begin
                    read_word = read_bus;
                    if (req_action == ACT_DELETE)
                    begin
                        cmd.shift_dn = req_acc;
                        count_next   = count_reg - 1'b1;
                    end
                end
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // row of cells, each wired to its two neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_v;
        logic [WORD_W-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid_r
            assign right_v = cell_value[i+1];
        end

        pls_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .ins_word    (req_word),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[i]),
            .tap         (cell_tap[i])
        );
    end

    // only the addressed cell drives a nonzero tap
    always_comb
    begin
        read_bus = '0;
        for (int k = 0; k < DEPTH; k++)
            read_bus = read_bus | cell_tap[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (req_acc)
                count_reg <= count_next;
            if (req_acc)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            out_status_reg <= status;
            out_read_reg   <= read_word;
            out_len_reg    <= count_next;
        end
    end

    // accept while the result slot is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_read_reg, out_status_reg};

    // fill never exceeds the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {3'b000, count_reg} <= DEPTH_W8)
        else $error("fill count beyond cell count");

    // clear empties the list
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && req_action == ACT_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries");

    // successful insert grows the list by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && cmd.shift_up) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow list");

    // every accepted request leaves a result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> m_tvalid)
        else $error("accepted request produced no result");

    // reported length matches the stored fill
    a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> (out_len_reg == count_reg))
        else $error("reported length differs from fill count");

endmodule

@@ hdl/pls_cell.sv @@
// pls_cell: one entry of the list with its neighbor shift logic
// depends on pls_pkg
module pls_cell
    import pls_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  pls_cmd_t          cmd,
    input  logic [WORD_W-1:0] ins_word,
    input  logic [WORD_W-1:0] left_value,
    input  logic [WORD_W-1:0] right_value,
    output logic [WORD_W-1:0] value,
    output logic [WORD_W-1:0] tap
);

    localparam logic [POS_W-1:0] IDX    = POS_W'(INDEX);
    localparam logic [POS_W:0]   IDX_P1 = (POS_W + 1)'(INDEX + 1);

    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;
    logic [POS_W-1:0]  count_ext;

    assign count_ext = POS_W'(cmd.count);

    always_comb
    begin
        value_next = value_reg;
        if (cmd.shift_up)
        begin
            if (IDX == cmd.pos)
                value_next = ins_word;
            else if (IDX > cmd.pos && IDX <= count_ext)
                value_next = left_value;
        end
        else if (cmd.shift_dn)
        begin
            if (IDX >= cmd.pos && IDX_P1 < {1'b0, count_ext})
                value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    // contributes to the shared read bus only when addressed
    assign tap   = (IDX == cmd.pos) ? value_reg : '0;

endmodule
